// ===== hw/rtl/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

	// Input word as seen on the push side
	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  seq_in;
		logic [63:0] payload_in;
	} item_t;

	// Result word as seen on the pop side
	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  seq_out;
		logic [63:0] payload_out;
		logic        last;
	} result_t;

	// Classified command handed from the front queue to the engine
	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  seq;
		logic        seq_ok;
		logic [63:0] payload;
	} cmd_t;

	// Configuration registers
	typedef struct packed {
		logic [3:0]  window_size;
		logic [15:0] timeout_ticks;
	} cfg_t;

	// Event codes
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_ACK  = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// Result codes
	localparam logic [2:0] KIND_IDLE    = 3'd0;
	localparam logic [2:0] KIND_DATA    = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_DELIVER = 3'd3;
	localparam logic [2:0] KIND_FULL    = 3'd4;

	// Register indexes
	localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
	localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;

	// Reset values
	localparam logic [3:0]  WINDOW_RESET    = 4'd14;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
	localparam logic [3:0]  LAST_GOOD_RESET = 4'hF;

endpackage

`default_nettype wire

// ===== hw/rtl/gbn_front.sv =====
`default_nettype none

module gbn_front #(
	parameter int SEQ_SPACE    = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire gbn_pkg::item_t item,
	output logic                cmd_valid,
	input  wire logic           cmd_pop,
	output gbn_pkg::cmd_t       cmd
);

	localparam int SW = $clog2(SEQ_SPACE);
	localparam int XW = ((SW > 4) ? SW : 4) + 1;
	localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

	gbn_pkg::cmd_t ent_q [2];
	gbn_pkg::cmd_t cls;
	logic [1:0]    cnt_q;
	logic          wp_q;
	logic          rp_q;
	logic          wr_en;
	logic          rd_en;

	// Classify the incoming word: mask payload, flag sequence numbers in range
	always_comb begin
		cls.op      = item.opcode;
		cls.seq     = item.seq_in;
		cls.seq_ok  = XW'(item.seq_in) < XW'(SEQ_SPACE);
		cls.payload = item.payload_in & PAY_MASK;
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rp_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	// Hold classified words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wp_q] <= cls;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd_en) begin
				rp_q <= ~rp_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_back.sv =====
`default_nettype none

module gbn_back #(
	parameter int SEQ_SPACE    = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gbn_pkg::cfg_t cfg,
	input  wire logic          cmd_valid,
	input  wire gbn_pkg::cmd_t cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	input  wire logic          res_ready,
	output gbn_pkg::result_t   res
);

	localparam int SW = $clog2(SEQ_SPACE);
	localparam int XW = ((SW > 4) ? SW : 4) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DACK = 3'd1;
	localparam logic [2:0] ST_TCHK = 3'd2;
	localparam logic [2:0] ST_RSEM = 3'd3;
	localparam logic [2:0] ST_RSRD = 3'd4;

	logic [2:0]    state_q;
	logic [SW-1:0] base_q;
	logic [SW-1:0] next_q;
	logic [SW-1:0] inflt_q;
	logic [SW-1:0] expect_q;
	logic [3:0]    last_good_q;
	logic          timer_q;
	logic [31:0]   tick_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] idx_q;
	logic [3:0]    dseq_q;

	logic [PAYLOAD_BITS-1:0] frame_mem [SEQ_SPACE];
	logic [31:0]             sent_mem [SEQ_SPACE];
	logic [PAYLOAD_BITS-1:0] frame_rd_q;
	logic [31:0]             sent_rd_q;

	logic [XW-1:0] win_x;
	logic [XW-1:0] lim_x;
	logic          can_send;
	logic [SW-1:0] seq_s;
	logic [SW:0]   off_w;
	logic [SW-1:0] off;
	logic [SW:0]   sum_w;
	logic [SW-1:0] base_new;
	logic          ack_hit;
	logic          good_data;
	logic [31:0]   age;
	logic          timed_out;
	logic          rs_last;
	logic          frame_we;
	logic          sent_we;
	logic [SW-1:0] sent_wa;

	function automatic logic [SW-1:0] inc_mod(input logic [SW-1:0] v);
		inc_mod = (v == SW'(SEQ_SPACE - 1)) ? '0 : v + SW'(1);
	endfunction

	// Window check against the effective window
	always_comb begin
		win_x    = XW'(cfg.window_size);
		lim_x    = XW'(SEQ_SPACE - 1);
		can_send = XW'(inflt_q) < ((win_x < lim_x) ? win_x : lim_x);
	end

	// Cumulative ack: distance from base and new base
	always_comb begin
		seq_s = SW'(cmd.seq);
		if (seq_s >= base_q) begin
			off_w = (SW+1)'(seq_s) - (SW+1)'(base_q);
		end else begin
			off_w = (SW+1)'(seq_s) + (SW+1)'(SEQ_SPACE) - (SW+1)'(base_q);
		end
		off   = SW'(off_w);
		sum_w = (SW+1)'(base_q) + (SW+1)'(off) + (SW+1)'(1);
		if (sum_w >= (SW+1)'(SEQ_SPACE)) begin
			base_new = SW'(sum_w - (SW+1)'(SEQ_SPACE));
		end else begin
			base_new = SW'(sum_w);
		end
		ack_hit = cmd.seq_ok && (off < inflt_q);
	end

	assign good_data = (XW'(cmd.seq) == XW'(expect_q));
	assign age       = tick_q - sent_rd_q;
	assign timed_out = timer_q && (inflt_q != '0) && (age > 32'(cfg.timeout_ticks));
	assign rs_last   = ((idx_q + SW'(1)) == inflt_q);

	// Result word and command pop
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		cmd_pop   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						gbn_pkg::OP_SEND: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (can_send) begin
								res.kind        = gbn_pkg::KIND_DATA;
								res.seq_out     = 4'(next_q);
								res.payload_out = cmd.payload;
							end else begin
								res.kind = gbn_pkg::KIND_FULL;
							end
							cmd_pop = res_ready;
						end
						gbn_pkg::OP_ACK: begin
							res_valid = 1'b1;
							res.kind  = gbn_pkg::KIND_IDLE;
							res.last  = 1'b1;
							cmd_pop   = res_ready;
						end
						gbn_pkg::OP_DATA: begin
							res_valid = 1'b1;
							if (good_data) begin
								res.kind        = gbn_pkg::KIND_DELIVER;
								res.seq_out     = cmd.seq;
								res.payload_out = cmd.payload;
							end else begin
								res.kind    = gbn_pkg::KIND_ACK;
								res.seq_out = last_good_q;
								res.last    = 1'b1;
							end
							cmd_pop = res_ready;
						end
						gbn_pkg::OP_TICK: begin
							cmd_pop = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_DACK: begin
				res_valid   = 1'b1;
				res.kind    = gbn_pkg::KIND_ACK;
				res.seq_out = dseq_q;
				res.last    = 1'b1;
			end
			ST_TCHK: begin
				if (!timed_out) begin
					res_valid = 1'b1;
					res.kind  = gbn_pkg::KIND_IDLE;
					res.last  = 1'b1;
				end
			end
			ST_RSEM: begin
				res_valid       = 1'b1;
				res.kind        = gbn_pkg::KIND_DATA;
				res.seq_out     = 4'(slot_q);
				res.payload_out = 64'(frame_rd_q);
				res.last        = rs_last;
			end
			default: ;
		endcase
	end

	// Store and stamp writes
	always_comb begin
		frame_we = (state_q == ST_IDLE) && cmd_pop && (cmd.op == gbn_pkg::OP_SEND) && can_send;
		sent_we  = frame_we || ((state_q == ST_RSEM) && res_ready);
		sent_wa  = (state_q == ST_RSEM) ? slot_q : next_q;
	end

	// Frame store and send stamps, registered reads
	always_ff @(posedge clk) begin
		if (frame_we) begin
			frame_mem[next_q] <= cmd.payload[PAYLOAD_BITS-1:0];
		end
		if (sent_we) begin
			sent_mem[sent_wa] <= tick_q;
		end
		frame_rd_q <= frame_mem[slot_q];
		sent_rd_q  <= sent_mem[base_q];
	end

	// Sender and receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			inflt_q     <= '0;
			expect_q    <= '0;
			last_good_q <= gbn_pkg::LAST_GOOD_RESET;
			timer_q     <= 1'b0;
			tick_q      <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			dseq_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							gbn_pkg::OP_SEND: begin
								if (can_send) begin
									next_q  <= inc_mod(next_q);
									inflt_q <= inflt_q + SW'(1);
									if (inflt_q == '0) begin
										timer_q <= 1'b1;
									end
								end
							end
							gbn_pkg::OP_ACK: begin
								if (ack_hit) begin
									base_q  <= base_new;
									inflt_q <= inflt_q - off - SW'(1);
									if (inflt_q == off + SW'(1)) begin
										timer_q <= 1'b0;
									end
								end
							end
							gbn_pkg::OP_DATA: begin
								if (good_data) begin
									dseq_q  <= cmd.seq;
									state_q <= ST_DACK;
								end
							end
							gbn_pkg::OP_TICK: begin
								tick_q  <= tick_q + 32'd1;
								slot_q  <= base_q;
								idx_q   <= '0;
								state_q <= ST_TCHK;
							end
							default: ;
						endcase
					end
				end
				ST_DACK: begin
					if (res_ready) begin
						last_good_q <= dseq_q;
						expect_q    <= inc_mod(expect_q);
						state_q     <= ST_IDLE;
					end
				end
				ST_TCHK: begin
					if (timed_out) begin
						state_q <= ST_RSEM;
					end else if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RSEM: begin
					if (res_ready) begin
						slot_q  <= inc_mod(slot_q);
						idx_q   <= idx_q + SW'(1);
						state_q <= rs_last ? ST_IDLE : ST_RSRD;
					end
				end
				ST_RSRD: begin
					state_q <= ST_RSEM;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_rq.sv =====
`default_nettype none

module gbn_rq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gbn_pkg::result_t in_res,
	output logic                  empty,
	input  wire logic             pop,
	output gbn_pkg::result_t      result
);

	gbn_pkg::result_t ent_q [2];
	logic [1:0]       cnt_q;
	logic             wp_q;
	logic             rp_q;
	logic             wr_en;
	logic             rd_en;

	assign in_ready = (cnt_q != 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign result   = ent_q[rp_q];
	assign wr_en    = in_valid && in_ready;
	assign rd_en    = pop && !empty;

	// Hold result words
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wp_q] <= in_res;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= ~wp_q;
			end
			if (rd_en) begin
				rp_q <= ~rp_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/go_back_n_arq_endpoint.sv =====
// Go-Back-N endpoint: sender window and in-order receiver in one block.
// Input queue: write an event word (send, ack received, data received, tick)
// with push while full is low. Result queue: while empty is low the oldest
// result word sits on result; pop takes it. Every event gives one or more
// results, the final one with last set.
// Config: cfg_valid/cfg_ready write window_size (index 0) or timeout_ticks
// (index 1); cfg_ready is always high. Write only while the block is idle.
// Flow: a pushed word is registered in the input queue before the engine
// sees it. Sends, acks and out-of-order data are answered from the idle
// state; in-order data gives a deliver, then an ack; a tick passes a check
// state, as the base frame's send stamp comes from a registered memory port.
// A timeout resend emits each frame in flight, with a read state between
// frames for the registered frame store read; input waits in the two-word input queue.
// Reset clears the window, the receiver state and both queues; the frame
// store and stamps are not cleared, and only in-flight entries are used.
// When the receiver stops popping, the two-word result queue fills, the
// engine holds, and full rises once the input queue backs up.
`default_nettype none

module go_back_n_arq_endpoint #(
	parameter int SEQ_SPACE    = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire gbn_pkg::item_t   item,
	output logic                  empty,
	input  wire logic             pop,
	output gbn_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);

	gbn_pkg::cfg_t    cfg_q;
	logic             cmd_valid;
	logic             cmd_pop;
	gbn_pkg::cmd_t    cmd;
	logic             res_valid;
	logic             res_ready;
	gbn_pkg::result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= gbn_pkg::WINDOW_RESET;
			cfg_q.timeout_ticks <= gbn_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gbn_pkg::REG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_data[3:0];
				gbn_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	gbn_front #(
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	gbn_back #(
		.SEQ_SPACE    (SEQ_SPACE),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	gbn_rq u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
